FILE: rtl/hsv_pkg.sv
// Shared types for the hue replace pipeline.
package hsv_pkg;

	typedef enum logic [2:0] {
		SEXT_0 = 3'd0,
		SEXT_1 = 3'd1,
		SEXT_2 = 3'd2,
		SEXT_3 = 3'd3,
		SEXT_4 = 3'd4,
		SEXT_5 = 3'd5
	} hsv_sext_t;

	typedef struct packed {
		logic [7:0] max1;
		logic [7:0] min1;
	} hsv_src_t;

	typedef struct packed {
		hsv_sext_t  sext;
		logic [7:0] rem;
		logic [7:0] divisor;
	} hsv_hue_t;

endpackage

FILE: rtl/hsv_in_if.sv
// Input channel: one source pixel and one hue reference pixel per item.
interface hsv_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] src_red;
	logic [7:0] src_green;
	logic [7:0] src_blue;
	logic [7:0] ref_red;
	logic [7:0] ref_green;
	logic [7:0] ref_blue;

	modport source (
		output valid, src_red, src_green, src_blue, ref_red, ref_green, ref_blue,
		input  ready
	);
	modport sink (
		input  valid, src_red, src_green, src_blue, ref_red, ref_green, ref_blue,
		output ready
	);
endinterface

FILE: rtl/hsv_out_if.sv
// Output channel: one recolored pixel per item.
interface hsv_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_red;
	logic [7:0] out_green;
	logic [7:0] out_blue;

	modport source (
		output valid, out_red, out_green, out_blue,
		input  ready
	);
	modport sink (
		input  valid, out_red, out_green, out_blue,
		output ready
	);
endinterface

FILE: rtl/hsv_pre.sv
// Front stages: channel max and min, scaled reference hue, sextant and remainder.
module hsv_pre (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              pair_valid,
	input  logic [7:0]        src_red,
	input  logic [7:0]        src_green,
	input  logic [7:0]        src_blue,
	input  logic [7:0]        ref_red,
	input  logic [7:0]        ref_green,
	input  logic [7:0]        ref_blue,
	output logic              hue_valid,
	output hsv_pkg::hsv_src_t src,
	output hsv_pkg::hsv_hue_t hue
);
	import hsv_pkg::*;

	logic [7:0]  smax, smin, rmax, rmin, rdelta;
	logic [11:0] diff, six_d, hval;

	logic        valid_s1;
	logic [7:0]  smax_s1, smin_s1, rdelta_s1;
	logic [10:0] hue_s1;

	logic [10:0] m1, m2, m3, m4, m5, base, hrem;
	hsv_sext_t   sext;
	logic [7:0]  rem, divisor;

	logic        valid_s2;
	hsv_src_t    src_s2;
	hsv_hue_t    hue_s2;

	always_comb begin
		smax = src_red;
		if (src_green > smax) smax = src_green;
		if (src_blue > smax) smax = src_blue;
		smin = src_red;
		if (src_green < smin) smin = src_green;
		if (src_blue < smin) smin = src_blue;
		rmax = ref_red;
		if (ref_green > rmax) rmax = ref_green;
		if (ref_blue > rmax) rmax = ref_blue;
		rmin = ref_red;
		if (ref_green < rmin) rmin = ref_green;
		if (ref_blue < rmin) rmin = ref_blue;
		rdelta = rmax - rmin;
		six_d = {2'd0, rdelta, 2'b00} + {3'd0, rdelta, 1'b0};
		if (ref_red == rmax) begin
			diff = {4'd0, ref_green} - {4'd0, ref_blue};
			hval = diff[11] ? diff + six_d : diff;
		end else if (ref_green == rmax) begin
			diff = {4'd0, ref_blue} - {4'd0, ref_red};
			hval = diff + {3'd0, rdelta, 1'b0};
		end else begin
			diff = {4'd0, ref_red} - {4'd0, ref_green};
			hval = diff + {2'd0, rdelta, 2'b00};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= pair_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			smax_s1   <= smax;
			smin_s1   <= smin;
			rdelta_s1 <= rdelta;
			hue_s1    <= hval[10:0];
		end
	end

	always_comb begin
		m1 = {3'd0, rdelta_s1};
		m2 = {2'd0, rdelta_s1, 1'b0};
		m3 = m2 + m1;
		m4 = {1'b0, rdelta_s1, 2'b00};
		m5 = m4 + m1;
		if (rdelta_s1 == 8'd0) begin
			sext = SEXT_0;
			base = '0;
		end else if (hue_s1 >= m5) begin
			sext = SEXT_5;
			base = m5;
		end else if (hue_s1 >= m4) begin
			sext = SEXT_4;
			base = m4;
		end else if (hue_s1 >= m3) begin
			sext = SEXT_3;
			base = m3;
		end else if (hue_s1 >= m2) begin
			sext = SEXT_2;
			base = m2;
		end else if (hue_s1 >= m1) begin
			sext = SEXT_1;
			base = m1;
		end else begin
			sext = SEXT_0;
			base = '0;
		end
		hrem = hue_s1 - base;
		// grey reference: remainder 0 over divisor 1 gives a zero fraction
		rem     = (rdelta_s1 == 8'd0) ? 8'd0 : hrem[7:0];
		divisor = (rdelta_s1 == 8'd0) ? 8'd1 : rdelta_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			src_s2.max1    <= smax_s1;
			src_s2.min1    <= smin_s1;
			hue_s2.sext    <= sext;
			hue_s2.rem     <= rem;
			hue_s2.divisor <= divisor;
		end
	end

	assign hue_valid = valid_s2;
	assign src       = src_s2;
	assign hue       = hue_s2;

`ifndef ASSERT_OFF
	a_rem_below_divisor: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> hue_s2.rem < hue_s2.divisor)
		else $error("remainder not below divisor");
	a_src_order: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> src_s2.min1 <= src_s2.max1)
		else $error("source min above max");
`endif

endmodule

FILE: rtl/hsv_div.sv
// Restoring divider pipeline: one fraction bit per stage.
module hsv_div #(
	parameter int FRAC_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 hue_valid,
	input  hsv_pkg::hsv_src_t    src,
	input  hsv_pkg::hsv_hue_t    hue,
	output logic                 frac_valid,
	output hsv_pkg::hsv_src_t    frac_src,
	output hsv_pkg::hsv_sext_t   frac_sext,
	output logic [FRAC_BITS-1:0] frac
);
	import hsv_pkg::*;

	logic                 valid_s [FRAC_BITS+1];
	hsv_src_t             src_s   [FRAC_BITS+1];
	hsv_sext_t            sext_s  [FRAC_BITS+1];
	logic [7:0]           rem_s   [FRAC_BITS+1];
	logic [7:0]           dvs_s   [FRAC_BITS+1];
	logic [FRAC_BITS-1:0] quo_s   [FRAC_BITS+1];

	assign valid_s[0] = hue_valid;
	assign src_s[0]   = src;
	assign sext_s[0]  = hue.sext;
	assign rem_s[0]   = hue.rem;
	assign dvs_s[0]   = hue.divisor;
	assign quo_s[0]   = '0;

	for (genvar k = 0; k < FRAC_BITS; k++) begin : g_stage
		logic [8:0] twice, sub;
		logic       ge;

		assign twice = {rem_s[k], 1'b0};
		assign sub   = twice - {1'b0, dvs_s[k]};
		assign ge    = twice >= {1'b0, dvs_s[k]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[k+1] <= 1'b0;
			end else if (en) begin
				valid_s[k+1] <= valid_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				src_s[k+1]  <= src_s[k];
				sext_s[k+1] <= sext_s[k];
				dvs_s[k+1]  <= dvs_s[k];
				rem_s[k+1]  <= ge ? sub[7:0] : twice[7:0];
				quo_s[k+1]  <= {quo_s[k][FRAC_BITS-2:0], ge};
			end
		end
	end

	assign frac_valid = valid_s[FRAC_BITS];
	assign frac_src   = src_s[FRAC_BITS];
	assign frac_sext  = sext_s[FRAC_BITS];
	assign frac       = quo_s[FRAC_BITS];

`ifndef ASSERT_OFF
	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(!en && frac_valid) |=> (frac_valid && $stable(frac) && $stable(frac_sext)))
		else $error("divider output moved during stall");
	a_partial_rem: assert property (@(posedge clk) disable iff (!arst_n)
		frac_valid |-> rem_s[FRAC_BITS] < dvs_s[FRAC_BITS])
		else $error("final partial remainder not below divisor");
`endif

endmodule

FILE: rtl/hsv_mix.sv
// Back stages: scaled blend product and channel selection by sextant.
module hsv_mix #(
	parameter int FRAC_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 frac_valid,
	input  hsv_pkg::hsv_src_t    frac_src,
	input  hsv_pkg::hsv_sext_t   frac_sext,
	input  logic [FRAC_BITS-1:0] frac,
	output logic                 mix_valid,
	output logic [7:0]           red,
	output logic [7:0]           green,
	output logic [7:0]           blue
);
	import hsv_pkg::*;

	logic [7:0]           delta;
	logic [FRAC_BITS+7:0] prod_full;

	logic                 valid_s1;
	logic [7:0]           prod_s1, max_s1, min_s1;
	hsv_sext_t            sext_s1;

	logic [7:0]           dn, up, o_r, o_g, o_b;

	logic                 valid_s2;
	logic [7:0]           red_s2, green_s2, blue_s2;

	assign delta     = frac_src.max1 - frac_src.min1;
	assign prod_full = {{FRAC_BITS{1'b0}}, delta} * {8'd0, frac};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= frac_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= prod_full[FRAC_BITS+7:FRAC_BITS];
			max_s1  <= frac_src.max1;
			min_s1  <= frac_src.min1;
			sext_s1 <= frac_sext;
		end
	end

	always_comb begin
		dn = max_s1 - prod_s1;
		up = min_s1 + prod_s1;
		case (sext_s1)
			SEXT_0: begin
				o_r = max_s1; o_g = up;     o_b = min_s1;
			end
			SEXT_1: begin
				o_r = dn;     o_g = max_s1; o_b = min_s1;
			end
			SEXT_2: begin
				o_r = min_s1; o_g = max_s1; o_b = up;
			end
			SEXT_3: begin
				o_r = min_s1; o_g = dn;     o_b = max_s1;
			end
			SEXT_4: begin
				o_r = up;     o_g = min_s1; o_b = max_s1;
			end
			default: begin
				o_r = max_s1; o_g = min_s1; o_b = dn;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			red_s2   <= o_r;
			green_s2 <= o_g;
			blue_s2  <= o_b;
		end
	end

	assign mix_valid = valid_s2;
	assign red       = red_s2;
	assign green     = green_s2;
	assign blue      = blue_s2;

`ifndef ASSERT_OFF
	a_prod_bound: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> prod_s1 <= (max_s1 - min_s1))
		else $error("blend product exceeds source spread");
`endif

endmodule

FILE: rtl/hsv_hue_replace_unit.sv
// Top level of the hue replace pipeline.
//
//   channel  dir  fields                                   handshake
//   pair     in   src_red/green/blue, ref_red/green/blue   valid/ready
//   result   out  out_red/green/blue                       valid/ready
//
// One item per cycle sustained while result is not stalled; the
// divider yields one fraction bit per stage.
// Reset clears only the valid bits of every stage.
// A stall on result holds every stage at once; pair.ready follows
// result.ready whenever the output register is full.
module hsv_hue_replace_unit #(
	parameter int FRAC_BITS = 16
) (
	input logic       clk,
	input logic       arst_n,
	hsv_in_if.sink    pair,
	hsv_out_if.source result
);
	import hsv_pkg::*;

	logic                 en;
	logic                 hue_valid, frac_valid, mix_valid;
	hsv_src_t             src, frac_src;
	hsv_hue_t             hue;
	hsv_sext_t            frac_sext;
	logic [FRAC_BITS-1:0] frac;

	assign en         = !mix_valid || result.ready;
	assign pair.ready = en;

	hsv_pre u_pre (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.pair_valid (pair.valid),
		.src_red    (pair.src_red),
		.src_green  (pair.src_green),
		.src_blue   (pair.src_blue),
		.ref_red    (pair.ref_red),
		.ref_green  (pair.ref_green),
		.ref_blue   (pair.ref_blue),
		.hue_valid  (hue_valid),
		.src        (src),
		.hue        (hue)
	);

	hsv_div #(
		.FRAC_BITS (FRAC_BITS)
	) u_div (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.hue_valid  (hue_valid),
		.src        (src),
		.hue        (hue),
		.frac_valid (frac_valid),
		.frac_src   (frac_src),
		.frac_sext  (frac_sext),
		.frac       (frac)
	);

	hsv_mix #(
		.FRAC_BITS (FRAC_BITS)
	) u_mix (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.frac_valid (frac_valid),
		.frac_src   (frac_src),
		.frac_sext  (frac_sext),
		.frac       (frac),
		.mix_valid  (mix_valid),
		.red        (result.out_red),
		.green      (result.out_green),
		.blue       (result.out_blue)
	);

	assign result.valid = mix_valid;

endmodule
